// ===== src/lsdm_pkg.sv =====
`timescale 1ns / 1ps

package lsdm_pkg;

    // store geometry
    localparam int unsigned MEM_WORDS = 4096;
    localparam int unsigned WIDX_W    = $clog2(MEM_WORDS);
    localparam logic [29:0] WORD_LIMIT = 30'(MEM_WORDS);
    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(MEM_WORDS - 1);

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_RSVD = 2'd3;

    // lane masks and extension fills
    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
    localparam logic [31:0] BYTE_FILL = 32'hFFFF_FF00;
    localparam logic [31:0] HALF_FILL = 32'hFFFF_0000;

    // request beat
    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic        sign_extend;
        logic [31:0] store_data;
    } t_in_beat;

    // response beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        misaligned;
        logic        out_of_range;
    } t_out_beat;

    // decoded access control
    typedef struct packed {
        logic              bad;
        logic              mis;
        logic [WIDX_W-1:0] widx;
        logic [1:0]        lane;
    } t_acc_ctl;

endpackage

// ===== src/lsdm_ram.sv =====
`timescale 1ns / 1ps

module lsdm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port, read returns old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lsdm_decode.sv =====
`timescale 1ns / 1ps

module lsdm_decode
    import lsdm_pkg::*;
(
    input  t_in_beat    i_beat,
    input  logic [31:0] i_base,
    output t_acc_ctl    o_ctl
);

    logic [31:0] offset;
    logic        below;
    logic        beyond;
    logic        mis;

    // base subtraction and range checks
    assign offset = i_beat.address - i_base;
    assign below  = i_beat.address < i_base;
    assign beyond = offset[31:2] >= WORD_LIMIT;

    // alignment check on the wrapped offset
    always_comb begin
        unique case (i_beat.access_size)
            SZ_HALF: mis = offset[0];
            SZ_WORD: mis = |offset[1:0];
            default: mis = 1'b0;
        endcase
    end

    assign o_ctl.bad  = (i_beat.access_size == SZ_RSVD) || below || beyond;
    assign o_ctl.mis  = mis;
    assign o_ctl.widx = offset[WIDX_W+1:2];
    assign o_ctl.lane = offset[1:0];

endmodule

// ===== src/lsdm_lane.sv =====
`timescale 1ns / 1ps

module lsdm_lane
    import lsdm_pkg::*;
(
    input  logic [1:0]  i_size,
    input  logic        i_sext,
    input  logic [1:0]  i_lane,
    input  logic [31:0] i_wdata,
    input  logic [31:0] i_word,
    output logic [31:0] o_merged,
    output logic [31:0] o_loaded
);

    logic [4:0]  sh_byte;
    logic [4:0]  sh_half;
    logic [31:0] m_byte;
    logic [31:0] m_half;
    logic [31:0] v_byte;
    logic [31:0] v_half;

    // lane shifts: halfword ignores offset bit 0
    assign sh_byte = {i_lane, 3'b000};
    assign sh_half = {i_lane[1], 4'b0000};
    assign m_byte  = BYTE_MASK << sh_byte;
    assign m_half  = HALF_MASK << sh_half;

    // store merge into the addressed word
    always_comb begin
        unique case (i_size)
            SZ_BYTE: o_merged = (i_word & ~m_byte) | ((i_wdata << sh_byte) & m_byte);
            SZ_HALF: o_merged = (i_word & ~m_half) | ((i_wdata << sh_half) & m_half);
            default: o_merged = i_wdata;
        endcase
    end

    // load extract and extend
    assign v_byte = (i_word >> sh_byte) & BYTE_MASK;
    assign v_half = (i_word >> sh_half) & HALF_MASK;

    always_comb begin
        unique case (i_size)
            SZ_BYTE: o_loaded = (i_sext && v_byte[7])  ? (v_byte | BYTE_FILL) : v_byte;
            SZ_HALF: o_loaded = (i_sext && v_half[15]) ? (v_half | HALF_FILL) : v_half;
            default: o_loaded = i_word;
        endcase
    end

endmodule

// ===== src/load_store_data_memory.sv =====
`timescale 1ns / 1ps
// Byte/halfword/word data memory, little-endian, one access per beat.
// Request channel i_in_valid / o_in_stall carries op, address, size, sign
// extension and store data; response channel o_out_valid / i_out_stall
// returns read data plus misaligned and out-of-range flags, one response
// per request, in order. i_cfg_we with i_cfg_wdata sets the base address
// subtracted from every request address; write it only while idle.
// Pipeline: an accepted request is read from the RAM and captured in the
// access stage; merge/extract, write-back and the response register follow
// when that stage advances, which a receiver stall can hold off.
// Throughput: one request per cycle unless sweeping or receiver-stalled; the
// single RAM port pair does the read at acceptance and the merged write-back
// when the stage advances, forwarding the last write to the following access.
// Reset: synchronous, active low. Afterwards the block sweeps all MEM_WORDS
// (4096) words of the store to zero, one word per cycle, holding o_in_stall
// high; base register writes are taken meanwhile.
// Receiver stall: the response register holds; the in-flight stage waits
// behind it and o_in_stall rises only once that stage is blocked too.

module load_store_data_memory
    import lsdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0]       r_base;
    logic              r_clearing;
    logic [WIDX_W-1:0] r_clr_idx;

    logic              r_s1_valid;
    logic              r_s1_op;
    logic [1:0]        r_s1_size;
    logic              r_s1_sext;
    logic [31:0]       r_s1_wdata;
    t_acc_ctl          r_s1_ctl;

    logic              r_wr_valid;
    logic [WIDX_W-1:0] r_wr_idx;
    logic [31:0]       r_wr_data;

    logic [31:0]       r_last_read;
    logic              r_out_valid;
    t_out_beat         r_out;

    t_acc_ctl          dec_ctl;
    logic              in_acc;
    logic              s1_adv;
    logic              s1_we;
    logic              s1_ld;
    logic [31:0]       ram_rdata;
    logic [31:0]       s1_word;
    logic [31:0]       merged;
    logic [31:0]       loaded;
    logic              ram_we;
    logic [WIDX_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;

    // request decode
    lsdm_decode u_decode (
        .i_beat (i_in_beat),
        .i_base (r_base),
        .o_ctl  (dec_ctl)
    );

    // handshake control
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign s1_we      = s1_adv && !r_s1_ctl.bad && (r_s1_op == OP_STORE);
    assign s1_ld      = s1_adv && !r_s1_ctl.bad && (r_s1_op == OP_LOAD);

    // write port shared by the clearing sweep and store write-back
    assign ram_we    = r_clearing || s1_we;
    assign ram_waddr = r_clearing ? r_clr_idx : r_s1_ctl.widx;
    assign ram_wdata = r_clearing ? 32'h0000_0000 : merged;

    lsdm_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (dec_ctl.widx),
        .o_rdata (ram_rdata)
    );

    // forward the write that landed alongside this beat's read
    assign s1_word = (r_wr_valid && (r_wr_idx == r_s1_ctl.widx)) ? r_wr_data : ram_rdata;

    lsdm_lane u_lane (
        .i_size   (r_s1_size),
        .i_sext   (r_s1_sext),
        .i_lane   (r_s1_ctl.lane),
        .i_wdata  (r_s1_wdata),
        .i_word   (s1_word),
        .o_merged (merged),
        .o_loaded (loaded)
    );

    // base register and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= 32'h0000_0000;
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_clearing) begin
                if (r_clr_idx == LAST_WIDX) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + WIDX_W'(1);
                end
            end
        end
    end

    // access stage: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_last_read <= 32'h0000_0000;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_we) begin
                r_wr_valid <= 1'b1;
            end
            if (s1_ld) begin
                r_last_read <= loaded;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // access stage: payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_in_beat.op;
            r_s1_size  <= i_in_beat.access_size;
            r_s1_sext  <= i_in_beat.sign_extend;
            r_s1_wdata <= i_in_beat.store_data;
            r_s1_ctl   <= dec_ctl;
        end
        if (s1_we) begin
            r_wr_idx  <= r_s1_ctl.widx;
            r_wr_data <= merged;
        end
        if (s1_adv) begin
            r_out.read_data    <= s1_ld ? loaded : r_last_read;
            r_out.misaligned   <= r_s1_ctl.mis;
            r_out.out_of_range <= r_s1_ctl.bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef ASSERT_OFF
    // no store write-back may collide with the clearing sweep
    a_no_store_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s1_we)
        else $error("store write-back during clearing sweep");

    // sweep ends only after the last word has been cleared
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_idx) == LAST_WIDX)
        else $error("clearing sweep ended early");

    // an accepted beat occupies the access stage next cycle
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted beat lost before access stage");

    // a flagged beat repeats the previous loaded value
    a_flagged_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_ctl.bad) |=> o_out_beat.read_data == $past(r_last_read))
        else $error("flagged beat did not repeat last read data");

    // forwarding register tracks the latest write-back
    a_forward_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_we |=> r_wr_valid && (r_wr_idx == $past(r_s1_ctl.widx)))
        else $error("forwarding register out of step with write-back");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lsdm_pkg::*;

    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned SQUEEZE_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_beat = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_beat;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    load_store_data_memory dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // accesses waiting to be driven and responses waiting to arrive
    t_in_beat    access_q[$];
    t_out_beat   response_q[$];

    // private copy of the memory state
    logic [31:0] mem_image [MEM_WORDS];
    logic [31:0] last_load;
    logic [31:0] mem_base;

    // stimulus control
    logic [31:0] cur_base = '0;
    logic        quiet = 1'b0;
    logic        squeeze = 1'b0;
    logic        squeeze_arm = 1'b0;
    logic        beat_taken = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    // tallies
    int          fail_count = 0;
    int          n_checked = 0;
    int          n_loads = 0;
    int          n_stores = 0;
    int          n_flagged = 0;
    int          n_misaligned = 0;
    int          n_blocked = 0;
    int          n_bases = 0;

    task automatic note_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
        if (fail_count < 40)
            $display("MISMATCH at response %0d, %s: got %h, expected %h",
                     n_checked, what, seen, wanted);
        fail_count++;
    endtask

    // expected response of one access, updating the memory image
    function automatic t_out_beat predict_access(input t_in_beat a);
        t_out_beat   r;
        logic [31:0] offset;
        logic [29:0] widx_full;
        logic [1:0]  lane;
        logic [4:0]  b_sh;
        logic [4:0]  h_sh;
        logic [31:0] word;
        logic [31:0] mask;
        logic [31:0] v;
        logic        bad;
        offset    = a.address - mem_base;
        widx_full = offset[31:2];
        lane      = offset[1:0];
        b_sh      = {lane, 3'b000};
        h_sh      = {lane[1], 4'b0000};
        r.misaligned = 1'b0;
        bad = (a.access_size == SZ_RSVD);
        if (a.access_size == SZ_HALF)
            r.misaligned = offset[0];
        else if (a.access_size == SZ_WORD)
            r.misaligned = |lane;
        if (a.address < mem_base || widx_full >= 30'(MEM_WORDS))
            bad = 1'b1;
        r.out_of_range = bad;
        r.read_data    = last_load;
        if (!bad) begin
            word = mem_image[widx_full[WIDX_W-1:0]];
            if (a.op == OP_STORE) begin
                case (a.access_size)
                    SZ_BYTE: begin
                        mask = 32'h0000_00FF << b_sh;
                        word = (word & ~mask) | ((a.store_data << b_sh) & mask);
                    end
                    SZ_HALF: begin
                        mask = 32'h0000_FFFF << h_sh;
                        word = (word & ~mask) | ((a.store_data << h_sh) & mask);
                    end
                    default: word = a.store_data;
                endcase
                mem_image[widx_full[WIDX_W-1:0]] = word;
            end else begin
                case (a.access_size)
                    SZ_BYTE: begin
                        v = (word >> b_sh) & 32'h0000_00FF;
                        if (a.sign_extend && v[7])
                            v = v | 32'hFFFF_FF00;
                    end
                    SZ_HALF: begin
                        v = (word >> h_sh) & 32'h0000_FFFF;
                        if (a.sign_extend && v[15])
                            v = v | 32'hFFFF_0000;
                    end
                    default: v = word;
                endcase
                last_load   = v;
                r.read_data = v;
            end
        end
        return r;
    endfunction

    function automatic t_in_beat make_access(input logic op, input logic [31:0] addr,
                                             input logic [1:0] size, input logic sext,
                                             input logic [31:0] data);
        t_in_beat a;
        a.op          = op;
        a.address     = addr;
        a.access_size = size;
        a.sign_extend = sext;
        a.store_data  = data;
        return a;
    endfunction

    // mostly in-range accesses around a few hot words, with some faults and noise
    function automatic t_in_beat random_access();
        t_in_beat    a;
        int unsigned pick;
        int unsigned widx;
        logic [1:0]  lane;
        a.op          = 1'($urandom_range(0, 1));
        a.access_size = 2'($urandom_range(0, 2));
        a.sign_extend = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 11))
            0:       a.store_data = '0;
            1:       a.store_data = '1;
            2:       a.store_data = 32'h8080_8080;
            default: a.store_data = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70)
            widx = $urandom_range(0, 15);
        else if (pick < 78)
            widx = MEM_WORDS - 1 - $urandom_range(0, 3);
        else
            widx = $urandom_range(0, MEM_WORDS - 1);
        lane = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 6) != 0) begin
            if (a.access_size == SZ_HALF)
                lane[0] = 1'b0;
            else if (a.access_size == SZ_WORD)
                lane = 2'b00;
        end
        a.address = cur_base + 32'(widx * 4) + 32'(lane);
        pick = $urandom_range(0, 99);
        if (pick >= 84 && pick < 90) begin
            a.access_size = SZ_RSVD;
        end else if (pick >= 90 && pick < 94) begin
            a.address = cur_base + 32'(MEM_WORDS * 4) + 32'($urandom_range(0, 255));
        end else if (pick >= 94 && pick < 97) begin
            if (cur_base != 0)
                a.address = $urandom_range(0, cur_base - 1);
            else
                a.address = $urandom;
        end else if (pick >= 97) begin
            a.address     = $urandom;
            a.access_size = 2'($urandom_range(0, 3));
        end
        return a;
    endfunction

    // accept requests and work out their responses
    always @(posedge i_clk) begin : predict_blk
        int w;
        t_out_beat r;
        if (!i_rst_n) begin
            for (w = 0; w < MEM_WORDS; w++)
                mem_image[w] = '0;
            last_load = '0;
            mem_base  = '0;
            beat_taken = 1'b0;
        end else begin
            if (i_cfg_we)
                mem_base = i_cfg_wdata;
            if (squeeze && i_in_valid && o_in_stall)
                n_blocked++;
            beat_taken = i_in_valid && !o_in_stall;
            if (beat_taken) begin
                r = predict_access(i_in_beat);
                response_q.push_back(r);
                if (r.out_of_range)
                    n_flagged++;
                else if (i_in_beat.op == OP_STORE)
                    n_stores++;
                else
                    n_loads++;
                if (r.misaligned)
                    n_misaligned++;
            end
        end
    end

    // request driver, fed from the access queue
    always @(negedge i_clk) begin : drive_blk
        logic     nv;
        t_in_beat nb;
        nv = i_in_valid;
        nb = i_in_beat;
        if (!i_in_valid || beat_taken) begin
            nv = 1'b0;
            if (quiet)
                src_gap = 0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (access_q.size() != 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 13);
                end else begin
                    nv = 1'b1;
                    nb = access_q.pop_front();
                end
            end
        end
        i_in_valid <= nv;
        i_in_beat  <= nb;
    end

    // receiver stall bursts, plus the long hold-off
    always @(negedge i_clk) begin : stall_blk
        logic ns;
        ns = 1'b0;
        if (quiet) begin
            snk_gap = 0;
        end else if (snk_gap > 0) begin
            ns = 1'b1;
            snk_gap--;
        end else if ($urandom_range(0, 7) == 0) begin
            ns = 1'b1;
            snk_gap = $urandom_range(0, 13);
        end
        i_out_stall <= ns || squeeze;
    end

    // long hold-off on the response side while requests keep coming
    initial begin
        wait (squeeze_arm);
        @(negedge i_clk);
        squeeze <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge i_clk);
        squeeze <= 1'b0;
    end

    // response monitor
    always @(posedge i_clk) begin : check_blk
        t_out_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (response_q.size() == 0) begin
                note_mismatch("response with nothing expected", o_out_beat.read_data, '0);
            end else begin
                e = response_q.pop_front();
                if (o_out_beat.read_data !== e.read_data)
                    note_mismatch("read_data", o_out_beat.read_data, e.read_data);
                if (o_out_beat.misaligned !== e.misaligned)
                    note_mismatch("misaligned", 32'(o_out_beat.misaligned),
                                  32'(e.misaligned));
                if (o_out_beat.out_of_range !== e.out_of_range)
                    note_mismatch("out_of_range", 32'(o_out_beat.out_of_range),
                                  32'(e.out_of_range));
            end
            n_checked++;
        end
    end

    task automatic set_base(input logic [31:0] b);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        cur_base     = b;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_bases++;
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            access_q.push_back(random_access());
    endtask

    // checked at the rising edge, once the driver's last update has settled
    task automatic drain();
        while (access_q.size() != 0 || i_in_valid || response_q.size() != 0)
            @(posedge i_clk);
    endtask

    // timeout
    initial begin
        #2_000_000;
        $display("load_store_data_memory verification failed");
        $finish;
    end

    // phases
    initial begin
        logic [31:0] top;
        top = 32'(MEM_WORDS * 4);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // base zero, taken during the clearing sweep
        set_base(32'h0000_0000);
        access_q.push_back(make_access(OP_LOAD,  32'h0, SZ_WORD, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'h0, SZ_WORD, 1'b0, 32'hFFFF_FFFF));
        access_q.push_back(make_access(OP_LOAD,  32'h1, SZ_BYTE, 1'b1, '0));
        access_q.push_back(make_access(OP_LOAD,  32'h1, SZ_BYTE, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'h2, SZ_BYTE, 1'b0, 32'h1234_5680));
        access_q.push_back(make_access(OP_LOAD,  32'h2, SZ_BYTE, 1'b1, '0));
        access_q.push_back(make_access(OP_STORE, 32'h6, SZ_HALF, 1'b0, 32'hABCD_8001));
        access_q.push_back(make_access(OP_LOAD,  32'h6, SZ_HALF, 1'b1, '0));
        access_q.push_back(make_access(OP_LOAD,  32'h6, SZ_HALF, 1'b0, '0));
        // misaligned halfword and word, low bits dropped
        access_q.push_back(make_access(OP_STORE, 32'h5, SZ_HALF, 1'b1, 32'hFFFF_7FFF));
        access_q.push_back(make_access(OP_LOAD,  32'h7, SZ_WORD, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'h3, SZ_WORD, 1'b0, 32'h0102_0304));
        access_q.push_back(make_access(OP_LOAD,  32'h1, SZ_HALF, 1'b1, '0));
        // reserved size changes nothing and repeats the last load
        access_q.push_back(make_access(OP_STORE, 32'h0, SZ_RSVD, 1'b0, 32'hDEAD_BEEF));
        access_q.push_back(make_access(OP_LOAD,  32'h3, SZ_RSVD, 1'b1, '0));
        // past the end of the store, alignment still reported
        access_q.push_back(make_access(OP_LOAD,  top, SZ_WORD, 1'b0, '0));
        access_q.push_back(make_access(OP_LOAD,  top + 1, SZ_HALF, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'hFFFF_FFFC, SZ_WORD, 1'b0, '1));
        // last word of the store
        access_q.push_back(make_access(OP_STORE, top - 4, SZ_WORD, 1'b0, 32'hA5A5_5A5A));
        access_q.push_back(make_access(OP_LOAD,  top - 1, SZ_BYTE, 1'b1, '0));
        access_q.push_back(make_access(OP_LOAD,  top - 4, SZ_WORD, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'h0, SZ_WORD, 1'b0, '0));
        queue_random(225);
        drain();

        // highest base: only one byte address maps into the store
        set_base(32'hFFFF_FFFF);
        access_q.push_back(make_access(OP_STORE, 32'hFFFF_FFFF, SZ_BYTE, 1'b0, 32'h0000_00C3));
        access_q.push_back(make_access(OP_LOAD,  32'hFFFF_FFFF, SZ_BYTE, 1'b1, '0));
        queue_random(225);
        drain();

        // unaligned base, with the long receiver hold-off
        set_base(32'h8000_0003);
        access_q.push_back(make_access(OP_LOAD,  32'h8000_0002, SZ_BYTE, 1'b0, '0));
        access_q.push_back(make_access(OP_STORE, 32'h0000_0000, SZ_WORD, 1'b0, '1));
        queue_random(225);
        squeeze_arm = 1'b1;
        drain();

        // random word-aligned base
        set_base($urandom & 32'hFFFF_FFFC);
        queue_random(225);
        drain();

        // small base, no idling on either side
        quiet <= 1'b1;
        set_base(32'h0000_0400);
        queue_random(225);
        drain();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (response_q.size() != 0)
            note_mismatch("responses never returned", 32'(response_q.size()), '0);
        $display("checked %0d responses: %0d loads, %0d stores, %0d flagged, %0d misaligned",
                 n_checked, n_loads, n_stores, n_flagged, n_misaligned);
        $display("%0d base settings, %0d cycles of request back-pressure under hold-off",
                 n_bases, n_blocked);
        if (fail_count == 0)
            $display("load_store_data_memory verification clean");
        else
            $display("load_store_data_memory verification failed");
        $finish;
    end

endmodule
